### sv/ltm_pkg.sv
// Shared types and constants for the latency/throughput monitor.
// No dependencies; used by every module of the block.
package ltm_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int AW          = $clog2(QUEUE_DEPTH);
  localparam int JOBQ_DEPTH  = 2;
  localparam int JQ_AW       = $clog2(JOBQ_DEPTH);
  localparam int QCW         = $clog2(JOBQ_DEPTH + 1);

  localparam int LEN_W   = 16;
  localparam int TIME_W  = 31;
  localparam int TOTAL_W = 48;
  localparam int LAT_W   = 32;
  localparam int TP_W    = 32;
  localparam int PROD_W  = 68;

  localparam logic [19:0]     SCALE  = 20'd1000000;
  localparam logic [TP_W-1:0] TP_MAX = '1;

  localparam logic OP_GEN  = 1'b0;
  localparam logic OP_SENT = 1'b1;

  // one popped message, handed from the front to the divider
  typedef struct packed {
    logic [LAT_W-1:0]   latency;
    logic [TOTAL_W-1:0] total;
    logic [TIME_W-1:0]  sent_time;
  } job_t;

  typedef struct packed {
    logic [QCW-1:0] count;
    logic           empty;
  } qstat_t;

endpackage

### sv/ltm_front.sv
// Front end: takes events, keeps the pending-message FIFO and byte total,
// and pushes one job per successful sent event. Depends on ltm_pkg.
module ltm_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            op,
  input  logic [ltm_pkg::TIME_W-1:0]      time_ms,
  input  logic [ltm_pkg::LEN_W-1:0]       length_bytes,
  input  ltm_pkg::qstat_t                 qstat,
  output logic                            busy,
  output logic                            push,
  output ltm_pkg::job_t                   push_job
);

  logic [ltm_pkg::LEN_W-1:0]  len_mem  [ltm_pkg::QUEUE_DEPTH];
  logic [ltm_pkg::TIME_W-1:0] time_mem [ltm_pkg::QUEUE_DEPTH];

  logic [ltm_pkg::AW-1:0]      head;
  logic [ltm_pkg::AW-1:0]      tail;
  logic [ltm_pkg::AW:0]        count;
  logic [ltm_pkg::TOTAL_W-1:0] byte_total;
  logic                        s2_valid;
  logic [ltm_pkg::TIME_W-1:0]  s2_time;
  logic [ltm_pkg::LEN_W-1:0]   rd_len;
  logic [ltm_pkg::TIME_W-1:0]  rd_time;

  logic                        accept;
  logic                        do_gen;
  logic                        do_sent;
  logic [ltm_pkg::QCW:0]       used;
  logic [ltm_pkg::TOTAL_W-1:0] total_next;

  // room is needed for the job in stage 2 plus one more
  assign used   = {1'b0, qstat.count} + (ltm_pkg::QCW+1)'(s2_valid);
  assign busy   = used >= (ltm_pkg::QCW+1)'(ltm_pkg::JOBQ_DEPTH);
  assign accept = start && !busy;
  assign do_gen = accept && (op == ltm_pkg::OP_GEN) &&
                  (count != (ltm_pkg::AW+1)'(ltm_pkg::QUEUE_DEPTH));
  assign do_sent = accept && (op == ltm_pkg::OP_SENT) && (count != '0);

  assign total_next = byte_total + ltm_pkg::TOTAL_W'(rd_len);

  assign push                = s2_valid;
  assign push_job.latency    = {1'b0, s2_time} - {1'b0, rd_time};
  assign push_job.total      = total_next;
  assign push_job.sent_time  = s2_time;

  always_ff @(posedge clk) begin
    if (do_gen) begin
      len_mem[tail]  <= length_bytes;
      time_mem[tail] <= time_ms;
    end
    if (do_sent) begin
      rd_len  <= len_mem[head];
      rd_time <= time_mem[head];
      s2_time <= time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      byte_total <= '0;
      s2_valid   <= 1'b0;
    end else begin
      s2_valid <= do_sent;
      if (s2_valid) begin
        byte_total <= total_next;
      end
      if (do_gen) begin
        tail  <= (tail == ltm_pkg::AW'(ltm_pkg::QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
        count <= count + 1'b1;
      end
      if (do_sent) begin
        head  <= (head == ltm_pkg::AW'(ltm_pkg::QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/ltm_jobq.sv
// Short job queue between the front end and the divider back end.
// Depends on ltm_pkg.
module ltm_jobq (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ltm_pkg::job_t   push_job,
  input  logic            pop,
  output ltm_pkg::job_t   head_job,
  output ltm_pkg::qstat_t qstat
);

  ltm_pkg::job_t              slots [ltm_pkg::JOBQ_DEPTH];
  logic [ltm_pkg::JQ_AW-1:0]  wr_ptr;
  logic [ltm_pkg::JQ_AW-1:0]  rd_ptr;
  logic [ltm_pkg::QCW-1:0]    count;

  assign head_job    = slots[rd_ptr];
  assign qstat.count = count;
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == ltm_pkg::JQ_AW'(ltm_pkg::JOBQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == ltm_pkg::JQ_AW'(ltm_pkg::JOBQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/ltm_back.sv
// Back end: scales the byte total by 1e6 and divides by the sent time
// (restoring, one quotient bit a cycle), saturating. Depends on ltm_pkg.
module ltm_back (
  input  logic                         clk,
  input  logic                         rst,
  input  ltm_pkg::qstat_t              qstat,
  input  ltm_pkg::job_t                head_job,
  output logic                         pop,
  output logic                         done,
  output logic [ltm_pkg::LAT_W-1:0]    latency_ms,
  output logic [ltm_pkg::TP_W-1:0]     throughput
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_CHK,
    S_DIV
  } state_t;

  state_t                      state;
  ltm_pkg::job_t               job;
  logic [51:0]                 p_lo;
  logic [35:0]                 p_hi;
  logic [ltm_pkg::PROD_W-1:0]  prod;
  logic [ltm_pkg::TIME_W-1:0]  rem;
  logic [ltm_pkg::TP_W-1:0]    dvd;
  logic [4:0]                  iter;

  logic [ltm_pkg::TIME_W:0]    trial;
  logic                        qbit;

  assign pop   = (state == S_IDLE) && !qstat.empty;
  assign trial = {rem, dvd[ltm_pkg::TP_W-1]};
  assign qbit  = trial >= {1'b0, job.sent_time};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!qstat.empty) begin
            job   <= head_job;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          p_lo  <= 52'(job.total[31:0]) * 52'(ltm_pkg::SCALE);
          p_hi  <= 36'(job.total[47:32]) * 36'(ltm_pkg::SCALE);
          state <= S_SUM;
        end
        S_SUM: begin
          prod  <= {p_hi, 32'b0} + ltm_pkg::PROD_W'(p_lo);
          state <= S_CHK;
        end
        S_CHK: begin
          latency_ms <= job.latency;
          // quotient needs more than 32 bits when the upper part reaches the divisor
          if ((job.sent_time == '0) ||
              (prod[ltm_pkg::PROD_W-1:32] >= 36'(job.sent_time))) begin
            throughput <= ltm_pkg::TP_MAX;
            done       <= 1'b1;
            state      <= S_IDLE;
          end else begin
            rem   <= prod[32 +: ltm_pkg::TIME_W];
            dvd   <= prod[31:0];
            iter  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem  <= qbit ? ltm_pkg::TIME_W'(trial - {1'b0, job.sent_time})
                       : trial[ltm_pkg::TIME_W-1:0];
          dvd  <= {dvd[ltm_pkg::TP_W-2:0], qbit};
          iter <= iter + 1'b1;
          if (iter == 5'd31) begin
            throughput <= {dvd[ltm_pkg::TP_W-2:0], qbit};
            done       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/latency_throughput_monitor.sv
// Latency/throughput monitor, top level.
// A sent event's done strobe follows its accepting edge through front read, queue,
// pop, 1e6 scaling in two stages, check and a 32-step divider (no divider when
// saturating); the back end takes a new sent event only after finishing the last.
// A generated event with a full FIFO, or a sent event with it empty, gives no result.
// Synchronous active-high rst clears pointers, counts and byte total.
module latency_throughput_monitor (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [30:0] time_ms,
  input  logic [15:0] length_bytes,
  output logic        done,
  output logic [31:0] latency_ms,
  output logic [31:0] throughput
);

  ltm_pkg::qstat_t qstat;
  ltm_pkg::job_t   push_job;
  ltm_pkg::job_t   head_job;
  logic            push;
  logic            pop;

  ltm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .op           (op),
    .time_ms      (time_ms),
    .length_bytes (length_bytes),
    .qstat        (qstat),
    .busy         (busy),
    .push         (push),
    .push_job     (push_job)
  );

  ltm_jobq u_jobq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .qstat    (qstat)
  );

  ltm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .qstat      (qstat),
    .head_job   (head_job),
    .pop        (pop),
    .done       (done),
    .latency_ms (latency_ms),
    .throughput (throughput)
  );

endmodule

### sim/ltm_result_checker.sv
// Result checker for the latency/throughput monitor: watches the event and
// result channels, predicts each sent event's latency and throughput, and compares.
// Depends on ltm_pkg for widths, op codes and the scale constant.
module ltm_result_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic                       op,
  input  logic [ltm_pkg::TIME_W-1:0] time_ms,
  input  logic [ltm_pkg::LEN_W-1:0]  length_bytes,
  input  logic                       done,
  input  logic [ltm_pkg::LAT_W-1:0]  latency_ms,
  input  logic [ltm_pkg::TP_W-1:0]   throughput,
  output int                         mismatches,
  output int                         outstanding
);

  typedef struct packed {
    logic [ltm_pkg::LAT_W-1:0] latency;
    logic [ltm_pkg::TP_W-1:0]  rate;
  } msg_result_t;

  // shadow copy of the message FIFO and the running byte total
  logic [ltm_pkg::LEN_W-1:0]   shadow_len  [ltm_pkg::QUEUE_DEPTH];
  logic [ltm_pkg::TIME_W-1:0]  shadow_time [ltm_pkg::QUEUE_DEPTH];
  int                          shadow_head;
  int                          shadow_count;
  logic [ltm_pkg::TOTAL_W-1:0] bytes_popped;
  msg_result_t                 awaited_results[$];

  // floor(total * 1e6 / t), saturating; a zero time saturates too
  function automatic logic [ltm_pkg::TP_W-1:0] scaled_rate(
      logic [ltm_pkg::TOTAL_W-1:0] total, logic [ltm_pkg::TIME_W-1:0] t);
    logic [79:0] prod;
    logic [79:0] quot;
    if (t == '0) return ltm_pkg::TP_MAX;
    prod = 80'(total) * 80'(ltm_pkg::SCALE);
    quot = prod / 80'(t);
    if (quot > 80'(ltm_pkg::TP_MAX)) return ltm_pkg::TP_MAX;
    return quot[ltm_pkg::TP_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("ltm check: %s at %0t: expected %h, got %h", what, $time, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    msg_result_t want;
    int          slot;
    if (rst) begin
      shadow_head  = 0;
      shadow_count = 0;
      bytes_popped = '0;
      awaited_results.delete();
    end else begin
      // results first: a result beat never belongs to the event accepted at this edge
      if (done) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result, latency", '0, latency_ms);
        end else begin
          want = awaited_results[0];
          awaited_results.delete(0);
          if (latency_ms !== want.latency)
            report_mismatch("latency_ms", want.latency, latency_ms);
          if (throughput !== want.rate)
            report_mismatch("throughput", want.rate, throughput);
        end
      end
      if (start && !busy) begin
        if (op == ltm_pkg::OP_GEN) begin
          if (shadow_count < ltm_pkg::QUEUE_DEPTH) begin
            slot = (shadow_head + shadow_count) % ltm_pkg::QUEUE_DEPTH;
            shadow_len[slot]  = length_bytes;
            shadow_time[slot] = time_ms;
            shadow_count++;
          end
        end else if (shadow_count != 0) begin
          bytes_popped = bytes_popped + ltm_pkg::TOTAL_W'(shadow_len[shadow_head]);
          want.latency = {1'b0, time_ms} - {1'b0, shadow_time[shadow_head]};
          want.rate    = scaled_rate(bytes_popped, time_ms);
          awaited_results = {awaited_results, want};
          shadow_head = (shadow_head + 1) % ltm_pkg::QUEUE_DEPTH;
          shadow_count--;
        end
      end
    end
    outstanding = awaited_results.size();
  end

endmodule

### sim/latency_throughput_monitor_test.sv
// Testbench top for the latency/throughput monitor: drives generated/sent
// events with random gaps and gives the verdict.
// Depends on ltm_pkg, latency_throughput_monitor and ltm_result_checker.
module latency_throughput_monitor_test;

  localparam int ITEM_TARGET = 1900;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 60;

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic                       op;
  logic [ltm_pkg::TIME_W-1:0] time_ms;
  logic [ltm_pkg::LEN_W-1:0]  length_bytes;
  logic                       done;
  logic [ltm_pkg::LAT_W-1:0]  latency_ms;
  logic [ltm_pkg::TP_W-1:0]   throughput;

  int                         mismatches;
  int                         outstanding;
  int                         stall_cycles;
  int                         useful_events;
  int                         fifo_fill;
  logic [ltm_pkg::TIME_W-1:0] clock_ms;

  latency_throughput_monitor dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .time_ms      (time_ms),
    .length_bytes (length_bytes),
    .done         (done),
    .latency_ms   (latency_ms),
    .throughput   (throughput)
  );

  ltm_result_checker chk (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .time_ms      (time_ms),
    .length_bytes (length_bytes),
    .done         (done),
    .latency_ms   (latency_ms),
    .throughput   (throughput),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // nothing accepted on either side for too long means the block hung
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL latency_throughput_monitor");
      $finish;
    end
  end

  // mostly a rising clock with small steps, plus wild and tiny times
  function automatic logic [ltm_pkg::TIME_W-1:0] pick_time();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) begin
      clock_ms = clock_ms + ltm_pkg::TIME_W'($urandom_range(0, 2000));
      return clock_ms;
    end
    if (r < 82) return ltm_pkg::TIME_W'($urandom);
    if (r < 94) return ltm_pkg::TIME_W'($urandom_range(0, 20));
    return ($urandom_range(1) != 0) ? '1 : '0;
  endfunction

  function automatic logic [ltm_pkg::LEN_W-1:0] pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return ltm_pkg::LEN_W'($urandom);
  endfunction

  // random hold-offs, none in a quiet window of the run
  task automatic maybe_idle();
    int gap;
    if (useful_events >= 700 && useful_events < 1000) return;
    if ($urandom_range(99) >= 10) return;
    gap = ($urandom_range(7) == 0) ? $urandom_range(5, 60) : $urandom_range(1, 4);
    @(negedge clk);
    start <= 1'b0;
    repeat (gap - 1) @(negedge clk);
  endtask

  // one event beat: hold start until the block takes it
  task automatic post_event(input logic kind, input logic [ltm_pkg::TIME_W-1:0] t,
                            input logic [ltm_pkg::LEN_W-1:0] len);
    maybe_idle();
    @(negedge clk);
    start        <= 1'b1;
    op           <= kind;
    time_ms      <= t;
    length_bytes <= len;
    do @(posedge clk); while (busy);
    if (kind == ltm_pkg::OP_GEN) begin
      if (fifo_fill < ltm_pkg::QUEUE_DEPTH) begin
        fifo_fill++;
        useful_events++;
      end
    end else if (fifo_fill > 0) begin
      fifo_fill--;
      useful_events++;
    end
  endtask

  initial begin
    int unsigned kind;
    int          seg;
    rst           = 1'b1;
    start         = 1'b0;
    op            = ltm_pkg::OP_GEN;
    time_ms       = '0;
    length_bytes  = '0;
    useful_events = 0;
    fifo_fill     = 0;
    clock_ms      = ltm_pkg::TIME_W'($urandom_range(0, 100000));
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty pops, zero and maximum times, negative latency,
    // zero-time and overflowing throughput
    post_event(ltm_pkg::OP_SENT, 31'd5, 16'h1234);
    post_event(ltm_pkg::OP_GEN, '0, '0);
    post_event(ltm_pkg::OP_SENT, '0, '1);
    post_event(ltm_pkg::OP_GEN, '1, '1);
    post_event(ltm_pkg::OP_SENT, '0, '0);
    post_event(ltm_pkg::OP_GEN, 31'd100, '1);
    post_event(ltm_pkg::OP_SENT, '1, '0);
    post_event(ltm_pkg::OP_GEN, 31'd1000, 16'd1);
    post_event(ltm_pkg::OP_SENT, 31'd1, '0);
    post_event(ltm_pkg::OP_GEN, 31'd5, 16'h5555);
    post_event(ltm_pkg::OP_GEN, 31'd6, 16'hAAAA);
    post_event(ltm_pkg::OP_SENT, 31'd1000000, '0);
    post_event(ltm_pkg::OP_SENT, 31'h5555_5555, '0);
    post_event(ltm_pkg::OP_SENT, '1, '1);
    post_event(ltm_pkg::OP_GEN, 31'h2AAA_AAAA, 16'h00FF);
    post_event(ltm_pkg::OP_SENT, 31'h2AAA_AAAA, '0);

    seg = 0;
    while (useful_events < ITEM_TARGET) begin
      kind = (seg == 0) ? 70 : $urandom_range(99);
      if (kind < 65) begin
        // well-formed traffic: pops never outrun pushes
        repeat (24) begin
          if (fifo_fill == 0 ||
              (fifo_fill < ltm_pkg::QUEUE_DEPTH && $urandom_range(1) != 0))
            post_event(ltm_pkg::OP_GEN, pick_time(), pick_length());
          else
            post_event(ltm_pkg::OP_SENT, pick_time(), pick_length());
        end
      end else if (kind < 80) begin
        // fill past full, then drain past empty
        while (fifo_fill < ltm_pkg::QUEUE_DEPTH)
          post_event(ltm_pkg::OP_GEN, pick_time(), pick_length());
        repeat ($urandom_range(1, 3)) post_event(ltm_pkg::OP_GEN, pick_time(), pick_length());
        while (fifo_fill > 0) post_event(ltm_pkg::OP_SENT, pick_time(), pick_length());
        repeat ($urandom_range(1, 2)) post_event(ltm_pkg::OP_SENT, pick_time(), pick_length());
      end else begin
        repeat (10) post_event(logic'($urandom_range(1)), ltm_pkg::TIME_W'($urandom),
                               ltm_pkg::LEN_W'($urandom));
      end
      seg++;
    end

    @(negedge clk);
    start <= 1'b0;
    wait (outstanding == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS latency_throughput_monitor");
    end else begin
      $display("FAIL latency_throughput_monitor");
    end
    $finish;
  end

endmodule
